// ----- rtl/quaternion_pose_compose_defines.svh -----
// Assertion helpers for the pose composition block.
`ifndef QUATERNION_POSE_COMPOSE_DEFINES_SVH
`define QUATERNION_POSE_COMPOSE_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define QPC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qpc assertion failed");

// Antecedent implies consequent in the next cycle.
`define QPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qpc assertion failed");

`else

`define QPC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define QPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/qpc_pkg.sv -----
package qpc_pkg;

   // Register map of the configuration port.
   typedef enum logic [2:0] {
      CSR_INIT_TX = 3'd0,
      CSR_INIT_TY = 3'd1,
      CSR_INIT_TZ = 3'd2,
      CSR_INIT_QR = 3'd3,
      CSR_INIT_QI = 3'd4,
      CSR_INIT_QJ = 3'd5,
      CSR_INIT_QK = 3'd6
   } csr_index_type;

   // Per-stage advance strobes shared by the two datapaths.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } qpc_adv_type;

   localparam int QUAT_FRAC  = 14;
   localparam int TRANS_FRAC = 28;

   localparam logic signed [34:0] QUAT_HALF  = 35'sd8192;
   localparam logic signed [60:0] TRANS_HALF = 61'sd134217728;

   localparam logic signed [20:0] QUAT_MAX  = 21'sd32767;
   localparam logic signed [20:0] QUAT_MIN  = -21'sd32768;
   localparam logic signed [33:0] TRANS_MAX = 34'sd8388607;
   localparam logic signed [33:0] TRANS_MIN = -34'sd8388608;

   localparam logic signed [15:0] QR_RESET = 16'sd16384;

   // Round to nearest (ties up) by 2^-14, then saturate to Q2.14.
   function automatic logic signed [15:0] qpc_round_sat_q(input logic signed [33:0] acc);
      logic signed [34:0] biased;
      logic signed [20:0] shifted;
      logic signed [15:0] res;
      biased  = 35'(acc) + QUAT_HALF;
      shifted = 21'(biased >>> QUAT_FRAC);
      if (shifted > QUAT_MAX) begin
         res = QUAT_MAX[15:0];
      end else if (shifted < QUAT_MIN) begin
         res = QUAT_MIN[15:0];
      end else begin
         res = shifted[15:0];
      end
      return res;
   endfunction

   // Round the rotated term by 2^-28, add the motion offset, saturate to 24 bits.
   function automatic logic signed [23:0] qpc_round_sat_t(input logic signed [59:0] acc,
                                                         input logic signed [23:0] mt);
      logic signed [60:0] biased;
      logic signed [32:0] shifted;
      logic signed [33:0] total;
      logic signed [23:0] res;
      biased  = 61'(acc) + TRANS_HALF;
      shifted = 33'(biased >>> TRANS_FRAC);
      total   = 34'(shifted) + 34'(mt);
      if (total > TRANS_MAX) begin
         res = TRANS_MAX[23:0];
      end else if (total < TRANS_MIN) begin
         res = TRANS_MIN[23:0];
      end else begin
         res = total[23:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/qpc_rotate.sv -----
module qpc_rotate
   import qpc_pkg::*;
(
   input  logic               clock,
   input  qpc_adv_type        adv,
   input  logic signed [15:0] move_qr,
   input  logic signed [15:0] move_qi,
   input  logic signed [15:0] move_qj,
   input  logic signed [15:0] move_qk,
   input  logic signed [23:0] move_tx,
   input  logic signed [23:0] move_ty,
   input  logic signed [23:0] move_tz,
   input  logic signed [23:0] init_tx,
   input  logic signed [23:0] init_ty,
   input  logic signed [23:0] init_tz,
   output logic signed [23:0] abs_tx,
   output logic signed [23:0] abs_ty,
   output logic signed [23:0] abs_tz
);

   // Stage 1: pairwise quaternion products
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [23:0] mt1_ff [3];
   // Stage 2: rotation matrix, scaled by 2^28
   logic signed [33:0] m_in [9];
   logic signed [33:0] m_ff [9];
   logic signed [23:0] mt2_ff [3];
   // Stage 3: matrix times initial translation
   logic signed [23:0] v [3];
   logic signed [57:0] p_in [9];
   logic signed [57:0] p_ff [9];
   logic signed [23:0] mt3_ff [3];
   // Stage 4: row sums
   logic signed [59:0] acc_in [3];
   logic signed [59:0] acc_ff [3];
   logic signed [23:0] mt4_ff [3];
   // Stage 5: rounded, offset and saturated
   logic signed [23:0] t_in [3];
   logic signed [23:0] t_ff [3];

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         ww_ff     <= move_qr * move_qr;
         xx_ff     <= move_qi * move_qi;
         yy_ff     <= move_qj * move_qj;
         zz_ff     <= move_qk * move_qk;
         xy_ff     <= move_qi * move_qj;
         xz_ff     <= move_qi * move_qk;
         yz_ff     <= move_qj * move_qk;
         wx_ff     <= move_qr * move_qi;
         wy_ff     <= move_qr * move_qj;
         wz_ff     <= move_qr * move_qk;
         mt1_ff[0] <= move_tx;
         mt1_ff[1] <= move_ty;
         mt1_ff[2] <= move_tz;
      end
   end

   always_comb begin
      m_in[0] = 34'(ww_ff) + 34'(xx_ff) - 34'(yy_ff) - 34'(zz_ff);
      m_in[1] = (34'(xy_ff) - 34'(wz_ff)) <<< 1;
      m_in[2] = (34'(xz_ff) + 34'(wy_ff)) <<< 1;
      m_in[3] = (34'(xy_ff) + 34'(wz_ff)) <<< 1;
      m_in[4] = 34'(ww_ff) - 34'(xx_ff) + 34'(yy_ff) - 34'(zz_ff);
      m_in[5] = (34'(yz_ff) - 34'(wx_ff)) <<< 1;
      m_in[6] = (34'(xz_ff) - 34'(wy_ff)) <<< 1;
      m_in[7] = (34'(yz_ff) + 34'(wx_ff)) <<< 1;
      m_in[8] = 34'(ww_ff) - 34'(xx_ff) - 34'(yy_ff) + 34'(zz_ff);
   end

   assign v[0] = init_tx;
   assign v[1] = init_ty;
   assign v[2] = init_tz;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p_in[3*r+c] = m_ff[3*r+c] * v[c];
         end
      end
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = 60'(p_ff[3*r]) + 60'(p_ff[3*r+1]) + 60'(p_ff[3*r+2]);
         t_in[r]   = qpc_round_sat_t(acc_ff[r], mt4_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         m_ff   <= m_in;
         mt2_ff <= mt1_ff;
      end
      if (adv.s3) begin
         p_ff   <= p_in;
         mt3_ff <= mt2_ff;
      end
      if (adv.s4) begin
         acc_ff <= acc_in;
         mt4_ff <= mt3_ff;
      end
      if (adv.s5) begin
         t_ff <= t_in;
      end
   end

   assign abs_tx = t_ff[0];
   assign abs_ty = t_ff[1];
   assign abs_tz = t_ff[2];

endmodule

// ----- rtl/quaternion_pose_compose.sv -----
// Pose composition: turns one relative motion sample into an absolute pose.
// Input channel (req_*): motion quaternion (Q2.14), motion translation and a
// frame tag; a transaction moves on req_valid and req_ready both high.
// Result channel (rsp_*): absolute quaternion = motion * initial quaternion,
// absolute translation = motion rotation applied to the initial translation
// plus the motion translation, both rounded once and saturated; the frame
// tag is copied through. One result for every input transaction.
// Configuration (csr_*): seven registers holding the initial pose, written by
// index; csr_ready is always high, an unknown index is dropped. Write only
// while the pipeline is empty.
// Pipeline: an accepted transaction passes through five register stages,
// set by the chained products of the rotation (products, matrix,
// matrix-vector products, sums, round and saturate), which sit in lockstep
// with the quaternion product. Throughput: one transaction per cycle while
// the output is not stalled by rsp_ready.
// Stall: when rsp_ready is low the output register holds; stages behind it
// keep advancing into empty slots and hold once full, so req_ready drops
// only when all five stages are occupied. Nothing is lost or repeated.
// Reset (synchronous): empties the pipeline and loads the identity pose.
`include "quaternion_pose_compose_defines.svh"

module quaternion_pose_compose
   import qpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_move_qr,
   input  logic [15:0] req_move_qi,
   input  logic [15:0] req_move_qj,
   input  logic [15:0] req_move_qk,
   input  logic [23:0] req_move_tx,
   input  logic [23:0] req_move_ty,
   input  logic [23:0] req_move_tz,
   input  logic [31:0] req_frame_tag,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_abs_qr,
   output logic [15:0] rsp_abs_qi,
   output logic [15:0] rsp_abs_qj,
   output logic [15:0] rsp_abs_qk,
   output logic [23:0] rsp_abs_tx,
   output logic [23:0] rsp_abs_ty,
   output logic [23:0] rsp_abs_tz,
   output logic [31:0] rsp_out_frame,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // Initial pose registers
   logic signed [23:0] init_tx_ff, init_ty_ff, init_tz_ff;
   logic signed [15:0] init_qr_ff, init_qi_ff, init_qj_ff, init_qk_ff;

   // Pipeline control: one valid bit per stage, stage 5 is the output register
   logic [4:0]  vld_ff;
   logic [4:0]  vld_in;
   qpc_adv_type adv;

   // Quaternion product path
   logic signed [15:0] mq [4];
   logic signed [15:0] iq [4];
   logic signed [31:0] qp_in  [16];
   logic signed [31:0] qp_ff  [16];
   logic signed [33:0] qsum_in [4];
   logic signed [33:0] qsum_ff [4];
   logic signed [15:0] qres_in [4];
   logic signed [15:0] qres3_ff [4];
   logic signed [15:0] qres4_ff [4];
   logic signed [15:0] qout_ff [4];

   // Frame tag delay line
   logic [31:0] tag_ff [5];

   logic signed [23:0] abs_tx, abs_ty, abs_tz;

   // ---------------------------------------------------------------------
   // Configuration: always ready, drop writes to an unknown index
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_tx_ff <= '0;
         init_ty_ff <= '0;
         init_tz_ff <= '0;
         init_qr_ff <= QR_RESET;
         init_qi_ff <= '0;
         init_qj_ff <= '0;
         init_qk_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_INIT_TX: init_tx_ff <= csr_wdata;
            CSR_INIT_TY: init_ty_ff <= csr_wdata;
            CSR_INIT_TZ: init_tz_ff <= csr_wdata;
            CSR_INIT_QR: init_qr_ff <= csr_wdata[15:0];
            CSR_INIT_QI: init_qi_ff <= csr_wdata[15:0];
            CSR_INIT_QJ: init_qj_ff <= csr_wdata[15:0];
            CSR_INIT_QK: init_qk_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: a stage advances when it is empty or the one after it moves
   // ---------------------------------------------------------------------
   always_comb begin
      adv.s5 = !vld_ff[4] || rsp_ready;
      adv.s4 = !vld_ff[3] || adv.s5;
      adv.s3 = !vld_ff[2] || adv.s4;
      adv.s2 = !vld_ff[1] || adv.s3;
      adv.s1 = !vld_ff[0] || adv.s2;

      vld_in    = vld_ff;
      if (adv.s1) vld_in[0] = req_valid;
      if (adv.s2) vld_in[1] = vld_ff[0];
      if (adv.s3) vld_in[2] = vld_ff[1];
      if (adv.s4) vld_in[3] = vld_ff[2];
      if (adv.s5) vld_in[4] = vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv.s1;
   assign rsp_valid = vld_ff[4];

   // ---------------------------------------------------------------------
   // Quaternion product: motion on the left, initial on the right
   // ---------------------------------------------------------------------
   assign mq[0] = req_move_qr;
   assign mq[1] = req_move_qi;
   assign mq[2] = req_move_qj;
   assign mq[3] = req_move_qk;
   assign iq[0] = init_qr_ff;
   assign iq[1] = init_qi_ff;
   assign iq[2] = init_qj_ff;
   assign iq[3] = init_qk_ff;

   always_comb begin
      // qp[4*m+i] is motion part m times initial part i
      for (int m = 0; m < 4; m++) begin
         for (int i = 0; i < 4; i++) begin
            qp_in[4*m+i] = mq[m] * iq[i];
         end
      end
      qsum_in[0] = 34'(qp_ff[0])  - 34'(qp_ff[5])  - 34'(qp_ff[10]) - 34'(qp_ff[15]);
      qsum_in[1] = 34'(qp_ff[1])  + 34'(qp_ff[4])  + 34'(qp_ff[11]) - 34'(qp_ff[14]);
      qsum_in[2] = 34'(qp_ff[2])  - 34'(qp_ff[7])  + 34'(qp_ff[8])  + 34'(qp_ff[13]);
      qsum_in[3] = 34'(qp_ff[3])  + 34'(qp_ff[6])  - 34'(qp_ff[9])  + 34'(qp_ff[12]);
      for (int k = 0; k < 4; k++) begin
         qres_in[k] = qpc_round_sat_q(qsum_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         qp_ff     <= qp_in;
         tag_ff[0] <= req_frame_tag;
      end
      if (adv.s2) begin
         qsum_ff   <= qsum_in;
         tag_ff[1] <= tag_ff[0];
      end
      if (adv.s3) begin
         qres3_ff  <= qres_in;
         tag_ff[2] <= tag_ff[1];
      end
      if (adv.s4) begin
         qres4_ff  <= qres3_ff;
         tag_ff[3] <= tag_ff[2];
      end
      if (adv.s5) begin
         qout_ff   <= qres4_ff;
         tag_ff[4] <= tag_ff[3];
      end
   end

   // ---------------------------------------------------------------------
   // Translation: rotate the initial translation, add the motion offset
   // ---------------------------------------------------------------------
   qpc_rotate u_rotate (
      .clock   (clock),
      .adv     (adv),
      .move_qr (req_move_qr),
      .move_qi (req_move_qi),
      .move_qj (req_move_qj),
      .move_qk (req_move_qk),
      .move_tx (req_move_tx),
      .move_ty (req_move_ty),
      .move_tz (req_move_tz),
      .init_tx (init_tx_ff),
      .init_ty (init_ty_ff),
      .init_tz (init_tz_ff),
      .abs_tx  (abs_tx),
      .abs_ty  (abs_ty),
      .abs_tz  (abs_tz)
   );

   assign rsp_abs_qr    = qout_ff[0];
   assign rsp_abs_qi    = qout_ff[1];
   assign rsp_abs_qj    = qout_ff[2];
   assign rsp_abs_qk    = qout_ff[3];
   assign rsp_abs_tx    = abs_tx;
   assign rsp_abs_ty    = abs_ty;
   assign rsp_abs_tz    = abs_tz;
   assign rsp_out_frame = tag_ff[4];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // An accepted transaction always lands in the first stage.
   `QPC_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld_ff[0])
   // A full stage behind a stalled output register holds its item.
   `QPC_ASSERT_NEXT(a_stall_holds, clock, reset, vld_ff[3] && !adv.s5, vld_ff[3])
   // A taken result with a successor waiting is replaced at once.
   `QPC_ASSERT_NEXT(a_no_bubble, clock, reset, rsp_valid && rsp_ready && vld_ff[3], rsp_valid)
   // Reset empties the whole pipeline.
   `QPC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, vld_ff == 5'd0)
   // A register write to the QR index lands in init_qr_ff.
   `QPC_ASSERT_NEXT(a_csr_qr, clock, reset,
                    csr_valid && (csr_index_type'(csr_index) == CSR_INIT_QR),
                    init_qr_ff == $past(csr_wdata[15:0]))

endmodule

// ----- tb/quaternion_pose_compose_tb.sv -----
module quaternion_pose_compose_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qpc_pkg::*;

   // Index beyond the register map: the block must drop the write.
   localparam logic [2:0] CSR_INDEX_NONE = 3'd7;

   // Cycles the receiver holds off in the back-pressure test.
   localparam int RSP_HOLD_CYCLES = 64;

   // One motion sample as it crosses the req_ channel.
   typedef struct packed {
      logic [15:0] qr;
      logic [15:0] qi;
      logic [15:0] qj;
      logic [15:0] qk;
      logic [23:0] tx;
      logic [23:0] ty;
      logic [23:0] tz;
      logic [31:0] frame;
   } move_sample_type;

   // One absolute pose as it leaves on the rsp_ channel.
   typedef struct packed {
      logic [15:0] qr;
      logic [15:0] qi;
      logic [15:0] qj;
      logic [15:0] qk;
      logic [23:0] tx;
      logic [23:0] ty;
      logic [23:0] tz;
      logic [31:0] frame;
   } pose_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_move_qr = '0;
   logic [15:0] req_move_qi = '0;
   logic [15:0] req_move_qj = '0;
   logic [15:0] req_move_qk = '0;
   logic [23:0] req_move_tx = '0;
   logic [23:0] req_move_ty = '0;
   logic [23:0] req_move_tz = '0;
   logic [31:0] req_frame_tag = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_abs_qr;
   logic [15:0] rsp_abs_qi;
   logic [15:0] rsp_abs_qj;
   logic [15:0] rsp_abs_qk;
   logic [23:0] rsp_abs_tx;
   logic [23:0] rsp_abs_ty;
   logic [23:0] rsp_abs_tz;
   logic [31:0] rsp_out_frame;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Our own copy of the initial pose, updated on every accepted register write.
   logic [23:0] init_tx = '0;
   logic [23:0] init_ty = '0;
   logic [23:0] init_tz = '0;
   logic [15:0] init_qr = QR_RESET;
   logic [15:0] init_qi = '0;
   logic [15:0] init_qj = '0;
   logic [15:0] init_qk = '0;

   // Absolute poses still owed by the block, oldest first.
   pose_type pose_expect_q[$];

   int error_count     = 0;
   int items_sent      = 0;
   int poses_checked   = 0;
   int csr_writes      = 0;

   // Set while a stretch without any idling on either side is running.
   bit no_idle = 1'b0;

   // The test bumps stall_requests; the receiver process notices and holds off.
   int stall_requests = 0;
   int stall_served   = 0;
   int hold_left      = 0;

   quaternion_pose_compose dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_move_qr   (req_move_qr),
      .req_move_qi   (req_move_qi),
      .req_move_qj   (req_move_qj),
      .req_move_qk   (req_move_qk),
      .req_move_tx   (req_move_tx),
      .req_move_ty   (req_move_ty),
      .req_move_tz   (req_move_tz),
      .req_frame_tag (req_frame_tag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_abs_qr    (rsp_abs_qr),
      .rsp_abs_qi    (rsp_abs_qi),
      .rsp_abs_qj    (rsp_abs_qj),
      .rsp_abs_qk    (rsp_abs_qk),
      .rsp_abs_tx    (rsp_abs_tx),
      .rsp_abs_ty    (rsp_abs_ty),
      .rsp_abs_tz    (rsp_abs_tz),
      .rsp_out_frame (rsp_out_frame),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Pose arithmetic
   // ------------------------------------------------------------------

   // Round to nearest by 2^-sh, ties towards plus infinity.
   function automatic longint round_half_up(input longint acc, input int sh);
      return (acc + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   // Clamp to the signed range of a field of the given width.
   function automatic longint clamp_signed(input longint v, input int width);
      longint hi;
      hi = (longint'(1) << (width - 1)) - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < -hi - 1) begin
         return -hi - 1;
      end
      return v;
   endfunction

   // Absolute pose for one motion sample under the current initial pose.
   // Rotation is q * (0,t0) * conj(q) written out as a matrix, without any
   // normalisation, so a non-unit q scales the vector by |q|^2.
   function automatic pose_type compose_pose(input move_sample_type m);
      longint w, x, y, z, a, b, c, d, vx, vy, vz;
      longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint rx, ry, rz, pr, pi, pj, pk;
      pose_type p;
      w  = longint'($signed(m.qr));
      x  = longint'($signed(m.qi));
      y  = longint'($signed(m.qj));
      z  = longint'($signed(m.qk));
      a  = longint'($signed(init_qr));
      b  = longint'($signed(init_qi));
      c  = longint'($signed(init_qj));
      d  = longint'($signed(init_qk));
      vx = longint'($signed(init_tx));
      vy = longint'($signed(init_ty));
      vz = longint'($signed(init_tz));
      ww = w * w;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      xy = x * y;
      xz = x * z;
      yz = y * z;
      wx = w * x;
      wy = w * y;
      wz = w * z;
      rx = (ww + xx - yy - zz) * vx + 2 * (xy - wz) * vy + 2 * (xz + wy) * vz;
      ry = 2 * (xy + wz) * vx + (ww - xx + yy - zz) * vy + 2 * (yz - wx) * vz;
      rz = 2 * (xz - wy) * vx + 2 * (yz + wx) * vy + (ww - xx - yy + zz) * vz;
      // Motion quaternion on the left of the Hamilton product.
      pr = w * a - x * b - y * c - z * d;
      pi = w * b + x * a + y * d - z * c;
      pj = w * c - x * d + y * a + z * b;
      pk = w * d + x * c - y * b + z * a;
      p.qr = 16'(clamp_signed(round_half_up(pr, QUAT_FRAC), 16));
      p.qi = 16'(clamp_signed(round_half_up(pi, QUAT_FRAC), 16));
      p.qj = 16'(clamp_signed(round_half_up(pj, QUAT_FRAC), 16));
      p.qk = 16'(clamp_signed(round_half_up(pk, QUAT_FRAC), 16));
      // The motion translation is added after rounding the rotated term.
      p.tx = 24'(clamp_signed(round_half_up(rx, TRANS_FRAC) + longint'($signed(m.tx)), 24));
      p.ty = 24'(clamp_signed(round_half_up(ry, TRANS_FRAC) + longint'($signed(m.ty)), 24));
      p.tz = 24'(clamp_signed(round_half_up(rz, TRANS_FRAC) + longint'($signed(m.tz)), 24));
      p.frame = m.frame;
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic move_sample_type make_motion(input logic [15:0] qr,
                                                   input logic [15:0] qi,
                                                   input logic [15:0] qj,
                                                   input logic [15:0] qk,
                                                   input logic [23:0] tx,
                                                   input logic [23:0] ty,
                                                   input logic [23:0] tz,
                                                   input logic [31:0] frame);
      move_sample_type m;
      m.qr    = qr;
      m.qi    = qi;
      m.qj    = qj;
      m.qk    = qk;
      m.tx    = tx;
      m.ty    = ty;
      m.tz    = tz;
      m.frame = frame;
      return m;
   endfunction

   // Mostly moderate parts (|q| near or below one), some full range, a few extremes.
   function automatic logic [15:0] rand_quat_part();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) begin
         return 16'($urandom_range(32767)) - 16'h4000;
      end
      if (pick < 9) begin
         return 16'($urandom);
      end
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         4:       return 16'h4000;
         default: return 16'hc000;
      endcase
   endfunction

   function automatic logic [23:0] rand_trans_part();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) begin
         return 24'($urandom_range(2097151)) - 24'h100000;
      end
      if (pick < 9) begin
         return 24'($urandom);
      end
      case ($urandom_range(3))
         0:       return 24'h800000;
         1:       return 24'h7fffff;
         2:       return 24'h000000;
         default: return 24'hffffff;
      endcase
   endfunction

   function automatic move_sample_type rand_motion();
      return make_motion(rand_quat_part(), rand_quat_part(), rand_quat_part(),
                         rand_quat_part(), rand_trans_part(), rand_trans_part(),
                         rand_trans_part(), $urandom());
   endfunction

   // Offer one motion sample; valid stays high with the payload held until
   // the transaction is taken. Log the expected pose at acceptance.
   task automatic send_motion(input move_sample_type m);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_move_qr   <= m.qr;
      req_move_qi   <= m.qi;
      req_move_qj   <= m.qj;
      req_move_qk   <= m.qk;
      req_move_tx   <= m.tx;
      req_move_ty   <= m.ty;
      req_move_tz   <= m.tz;
      req_frame_tag <= m.frame;
      req_valid     <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pose_expect_q.push_back(compose_pose(m));
      items_sent++;
   endtask

   // Drop valid and wait until every owed pose has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pose_expect_q.size() != 0);
   endtask

   // One register write transaction. csr_valid is left high so back-to-back
   // writes need no gap; the caller drops it after the last one.
   task automatic write_csr(input logic [2:0] idx, input logic [23:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_writes++;
      case (idx)
         CSR_INIT_TX: init_tx = data;
         CSR_INIT_TY: init_ty = data;
         CSR_INIT_TZ: init_tz = data;
         CSR_INIT_QR: init_qr = data[15:0];
         CSR_INIT_QI: init_qi = data[15:0];
         CSR_INIT_QJ: init_qj = data[15:0];
         CSR_INIT_QK: init_qk = data[15:0];
         default: ;
      endcase
   endtask

   // Load a whole initial pose. The spare upper bits of the quaternion
   // writes carry junk that the block must mask off.
   task automatic write_init_pose(input logic [23:0] tx, input logic [23:0] ty,
                                  input logic [23:0] tz, input logic [15:0] qr,
                                  input logic [15:0] qi, input logic [15:0] qj,
                                  input logic [15:0] qk, input logic [7:0] junk);
      write_csr(CSR_INIT_TX, tx);
      write_csr(CSR_INIT_TY, ty);
      write_csr(CSR_INIT_TZ, tz);
      write_csr(CSR_INIT_QR, {junk, qr});
      write_csr(CSR_INIT_QI, {~junk, qi});
      write_csr(CSR_INIT_QJ, {junk, qj});
      write_csr(CSR_INIT_QK, {~junk, qk});
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Receiver: random stalls, none while no_idle is set, and a long hold-off
   // on request, counted down here.
   always @(posedge clock) begin
      if (stall_requests != stall_served) begin
         stall_served <= stall_requests;
         hold_left    <= RSP_HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 6);
      end
   end

   // Compare each accepted result with the oldest owed pose.
   always @(posedge clock) begin
      pose_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pose_expect_q.size() == 0) begin
            $error("pose result with nothing owed, frame %0h", rsp_out_frame);
            error_count++;
         end else begin
            want = pose_expect_q.pop_front();
            check_field("abs_qr", longint'($signed(want.qr)), longint'($signed(rsp_abs_qr)));
            check_field("abs_qi", longint'($signed(want.qi)), longint'($signed(rsp_abs_qi)));
            check_field("abs_qj", longint'($signed(want.qj)), longint'($signed(rsp_abs_qj)));
            check_field("abs_qk", longint'($signed(want.qk)), longint'($signed(rsp_abs_qk)));
            check_field("abs_tx", longint'($signed(want.tx)), longint'($signed(rsp_abs_tx)));
            check_field("abs_ty", longint'($signed(want.ty)), longint'($signed(rsp_abs_ty)));
            check_field("abs_tz", longint'($signed(want.tz)), longint'($signed(rsp_abs_tz)));
            check_field("out_frame", longint'(want.frame), longint'(rsp_out_frame));
            poses_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset pose is identity: the output follows the motion directly.
   // Cover both frame tag extremes and translation extremes on the way.
   task automatic test_reset_pose();
      send_motion(make_motion(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0000));
      send_motion(make_motion(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                              24'h7fffff, 24'h800000, 24'h000001, 32'hffff_ffff));
      send_motion(make_motion(16'hc000, 16'h0000, 16'h0000, 16'h0000,
                              24'h800000, 24'h7fffff, 24'hffffff, 32'h0000_0001));
      wait_drained();
   endtask

   // Extreme quaternion parts on both sides: the product must saturate.
   task automatic test_quat_saturation();
      write_init_pose(24'h000100, 24'hffff00, 24'h000010,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 8'hff);
      send_motion(make_motion(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0010));
      send_motion(make_motion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0011));
      send_motion(make_motion(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                              24'h000005, 24'hfffffb, 24'h000000, 32'h0000_0012));
      wait_drained();
      write_init_pose(24'h000000, 24'h000000, 24'h000000,
                      16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 8'h5a);
      send_motion(make_motion(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0013));
      wait_drained();
   endtask

   // Large initial translation under a non-unit rotation overflows both
   // ways; a zero quaternion wipes the rotated term entirely.
   task automatic test_trans_saturation();
      write_init_pose(24'h7fffff, 24'h800000, 24'h7fffff,
                      16'h4000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_motion(make_motion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              24'h7fffff, 24'h7fffff, 24'h7fffff, 32'h0000_0020));
      send_motion(make_motion(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              24'h800000, 24'h800000, 24'h800000, 32'h0000_0021));
      send_motion(make_motion(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              24'h7fffff, 24'h800000, 24'h123456, 32'h0000_0022));
      // Quarter turn about z with norm about one.
      send_motion(make_motion(16'h2d41, 16'h0000, 16'h0000, 16'h2d41,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0023));
      wait_drained();
      write_init_pose(24'h800000, 24'h800000, 24'h800000,
                      16'h4000, 16'h0000, 16'h0000, 16'h0000, 8'h33);
      send_motion(make_motion(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                              24'h800000, 24'hffffff, 24'h7fffff, 32'h0000_0024));
      wait_drained();
   endtask

   // Exact half-way products: +0.5 rounds up to one, -0.5 rounds up to zero.
   task automatic test_rounding_ties();
      write_init_pose(24'h000001, 24'hffffff, 24'h000000,
                      16'h2000, 16'h2000, 16'he000, 16'h0000, 8'hc3);
      send_motion(make_motion(16'h0001, 16'h0000, 16'h0000, 16'h0000,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0030));
      send_motion(make_motion(16'hffff, 16'h0000, 16'h0000, 16'h0000,
                              24'h000000, 24'h000000, 24'h000000, 32'h0000_0031));
      send_motion(make_motion(16'h2d41, 16'h2d41, 16'h0000, 16'h0000,
                              24'h000003, 24'hfffffd, 24'h000000, 32'h0000_0032));
      wait_drained();
   endtask

   // A write to an index outside the map must leave the pose untouched.
   task automatic test_unused_index();
      write_csr(CSR_INDEX_NONE, 24'($urandom()));
      csr_valid <= 1'b0;
      send_motion(make_motion(16'h4000, 16'h1000, 16'hf000, 16'h0800,
                              24'h001000, 24'hfff000, 24'h000100, 32'h0000_0040));
      send_motion(rand_motion());
      wait_drained();
   endtask

   // Hold off the receiver for a long stretch while items keep coming,
   // so the pipeline fills and req_ready drops; then pause until empty.
   task automatic test_back_pressure();
      int n;
      stall_requests++;
      no_idle = 1'b1;
      for (n = 0; n < 40; n++) begin
         send_motion(rand_motion());
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   // Random phases, each under a fresh random initial pose. One phase runs
   // with no idling on either side.
   task automatic test_random_stream();
      int phase;
      int n;
      for (phase = 0; phase < 6; phase++) begin
         wait_drained();
         if ($urandom_range(3) == 0) begin
            write_csr(CSR_INDEX_NONE, 24'($urandom()));
         end
         write_init_pose(rand_trans_part(), rand_trans_part(), rand_trans_part(),
                         rand_quat_part(), rand_quat_part(), rand_quat_part(),
                         rand_quat_part(), 8'($urandom()));
         no_idle = (phase == 2);
         for (n = 0; n < 145; n++) begin
            send_motion(rand_motion());
         end
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_pose();
      test_quat_saturation();
      test_trans_saturation();
      test_rounding_ties();
      test_unused_index();
      test_back_pressure();
      test_random_stream();

      // Let the pipeline run dry; anything arriving now is a stray result.
      repeat (20) @(posedge clock);
      if (pose_expect_q.size() != 0) begin
         $error("%0d absolute poses never arrived", pose_expect_q.size());
         error_count++;
      end

      $display("run covered %0d motion samples and %0d register writes, with random",
               items_sent, csr_writes);
      $display("idling, a %0d-cycle result hold-off and %0d poses checked field by field",
               RSP_HOLD_CYCLES, poses_checked);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
